### hdl/depth_to_point_backprojection_top_macros.svh
// Assertion macros for the depth-to-point back-projection block.
// Used by the top level only; no other dependencies.
`ifndef DEPTH_TO_POINT_BACKPROJECTION_TOP_MACROS_SVH
`define DEPTH_TO_POINT_BACKPROJECTION_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define D2P_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("d2p: implication check failed");

// Fixed-delay implication, disabled during reset.
`define D2P_ASSERT_DELAY(label, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("d2p: delayed check failed");

`endif

### hdl/d2p_pkg.sv
// Shared sizes, constants and types of the depth-to-point back-projection block.
// No dependencies; imported by d2p_axis, the top level and the testbench.
package d2p_pkg;

    // Input field sizes.
    localparam int COORD_BITS = 12;
    localparam int DEPTH_BITS = 16;

    // Fixed register and result widths.
    localparam int INV_W   = 24;
    localparam int CTR_W   = 16;
    localparam int Z_W     = 32;
    localparam int PT_W    = 48;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 3;
    localparam int FRAC_W  = 16;

    // Pipeline length from accepted item to result strobe.
    localparam int PIPE_DEPTH = 6;

    // Millimeter scaling: z = floor((raw*8192 + 62) / 125), via a reciprocal.
    localparam int MM_SHIFT   = 13;
    localparam int MM_BIAS    = 62;
    localparam int MM_DIV     = 125;
    localparam int RECIP_SH   = 36;
    localparam int RECIP_W    = 30;
    localparam longint MM_RECIP = (64'd1 << RECIP_SH) / MM_DIV;
    localparam int M_W  = DEPTH_BITS + MM_SHIFT;
    localparam int QP_W = M_W + RECIP_W;
    localparam int Q_W  = QP_W - RECIP_SH;
    localparam int QK_W = M_W + 1;

    // Axis datapath widths.
    localparam int PIX4_W = COORD_BITS + 4;
    localparam int MAG_W  = (PIX4_W > CTR_W) ? PIX4_W : CTR_W;
    localparam int OFF_W  = MAG_W + 1;
    localparam int PM_W   = MAG_W + INV_W;
    localparam int PH_W   = PM_W + FRAC_W;
    localparam int S_W    = PH_W + FRAC_W + 1;
    localparam int RND_SH = 28;
    localparam int R_W    = S_W - RND_SH;
    localparam int RX_W   = (R_W > PT_W + 1) ? R_W : PT_W + 1;

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] REG_INV_FOCAL_X     = 3'd0;
    localparam logic [IDX_W-1:0] REG_INV_FOCAL_Y     = 3'd1;
    localparam logic [IDX_W-1:0] REG_CENTER_X        = 3'd2;
    localparam logic [IDX_W-1:0] REG_CENTER_Y        = 3'd3;
    localparam logic [IDX_W-1:0] REG_MILLIMETER_MODE = 3'd4;
    localparam logic [IDX_W-1:0] REG_MAX_DISTANCE    = 3'd5;

    // Register reset values.
    localparam logic [INV_W-1:0] RST_INV_FOCAL = 24'd33554;
    localparam logic [CTR_W-1:0] RST_CENTER_X  = 16'd5120;
    localparam logic [CTR_W-1:0] RST_CENTER_Y  = 16'd3200;
    localparam logic [Z_W-1:0]   RST_MAX_DIST  = 32'hFFFF_FFFF;

    // Intrinsics of one axis.
    typedef struct packed {
        logic [INV_W-1:0] inv;
        logic [CTR_W-1:0] center;
    } d2p_axis_cfg_t;

endpackage

### hdl/d2p_axis.sv
// One axis of the pinhole back-projection: (pix.4 - center) * inv * z, rounded and saturated.
// Depends on d2p_pkg; instantiated twice by the top level.
module d2p_axis
    import d2p_pkg::*;
(
    input  logic                    clk,
    input  logic [COORD_BITS-1:0]   pix,
    input  d2p_axis_cfg_t           cfg,
    input  logic [Z_W-1:0]          z,
    output logic signed [PT_W-1:0]  coord
);

    logic [OFF_W-1:0]  off;
    logic [MAG_W-1:0]  mag_next;
    logic [MAG_W-1:0]  mag_reg;
    logic              neg_a2_reg;
    logic [PM_W-1:0]   pm_reg;
    logic              neg_a3_reg;
    logic [PH_W-1:0]   ph_reg;
    logic [PH_W-1:0]   pl_reg;
    logic              neg_a4_reg;
    logic [S_W-1:0]    sum;
    logic [R_W-1:0]    r_reg;
    logic              neg_a5_reg;
    logic [RX_W-1:0]   rx;
    logic [RX_W-1:0]   sat;
    logic [PT_W-1:0]   coord_next;
    logic [PT_W-1:0]   coord_reg;

    localparam logic [RX_W-1:0] NEG_LIM = RX_W'(1) << (PT_W - 1);
    localparam logic [RX_W-1:0] POS_LIM = NEG_LIM - RX_W'(1);

    // Signed offset of the pixel from the principal point, split into sign and magnitude.
    always_comb
    begin
        off = OFF_W'({pix, 4'b0000}) - OFF_W'(cfg.center);
        if (off[OFF_W-1])
        begin
            mag_next = MAG_W'(~off + OFF_W'(1));
        end
        else
        begin
            mag_next = off[MAG_W-1:0];
        end
    end

    // Rounding sum: the full product plus one half at the Q.16 point.
    assign sum = (S_W'(ph_reg) << FRAC_W) + S_W'(pl_reg) + (S_W'(1) << (RND_SH - 1));

    // Saturate the magnitude and apply the sign.
    always_comb
    begin
        rx = RX_W'(r_reg);
        if (neg_a5_reg)
        begin
            sat = (rx > NEG_LIM) ? NEG_LIM : rx;
            coord_next = PT_W'(~sat + RX_W'(1));
        end
        else
        begin
            sat = (rx > POS_LIM) ? POS_LIM : rx;
            coord_next = sat[PT_W-1:0];
        end
    end

    // Datapath registers: offset, reciprocal product, partial products, rounded sum, result.
    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        neg_a2_reg <= off[OFF_W-1];
        pm_reg     <= PM_W'(mag_reg) * PM_W'(cfg.inv);
        neg_a3_reg <= neg_a2_reg;
        ph_reg     <= PH_W'(pm_reg) * PH_W'(z[Z_W-1:FRAC_W]);
        pl_reg     <= PH_W'(pm_reg) * PH_W'(z[FRAC_W-1:0]);
        neg_a4_reg <= neg_a3_reg;
        r_reg      <= sum[S_W-1:RND_SH];
        neg_a5_reg <= neg_a4_reg;
        coord_reg  <= coord_next;
    end

    assign coord = coord_reg;

endmodule

### hdl/depth_to_point_backprojection_top.sv
// Depth-to-point back-projection top level: depth scaling, config registers, two axis units.
// Depends on d2p_pkg, d2p_axis and the assertion macro header.
//
// One depth pixel is accepted in every cycle (busy stays low) and its point appears on the
// result ports at the end of the pipeline, marked by result_valid for exactly one cycle; the
// receiver cannot stall, so every result must be taken when it is strobed. The six register
// stages are input capture, offset, offset times reciprocal focal length, the two partial
// products with z, the rounding add, then saturation and sign. Depth scaling by 1/1000 in
// millimeter mode runs alongside in the first stages through a constant reciprocal multiply
// and one correction step. Configuration writes are always ready and take effect at once, so
// they belong in gaps where no item is in flight.
`include "depth_to_point_backprojection_top_macros.svh"

module depth_to_point_backprojection_top
    import d2p_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [DEPTH_BITS-1:0]   raw_depth,
    input  logic [COORD_BITS-1:0]   column,
    input  logic [COORD_BITS-1:0]   row,
    input  logic                    frame_end,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    output logic                    result_valid,
    output logic signed [PT_W-1:0]  point_x,
    output logic signed [PT_W-1:0]  point_y,
    output logic [Z_W-1:0]          point_z,
    output logic                    keep,
    output logic                    last_point
);

    logic                   accept;
    logic [PIPE_DEPTH-1:0]  vld_reg;

    logic [INV_W-1:0]       inv_focal_x_reg;
    logic [INV_W-1:0]       inv_focal_y_reg;
    logic [CTR_W-1:0]       center_x_reg;
    logic [CTR_W-1:0]       center_y_reg;
    logic                   mm_mode_reg;
    logic [Z_W-1:0]         max_dist_reg;

    logic [DEPTH_BITS-1:0]  raw_s1_reg;
    logic [COORD_BITS-1:0]  col_s1_reg;
    logic [COORD_BITS-1:0]  row_s1_reg;
    logic [PIPE_DEPTH-1:0]  fe_reg;

    logic [M_W-1:0]         m_s1;
    logic [QP_W-1:0]        qp_next;
    logic [Q_W-1:0]         q_s2_reg;
    logic [M_W-1:0]         m_s2_reg;
    logic [DEPTH_BITS-1:0]  raw_s2_reg;

    logic [QK_W-1:0]        qk;
    logic [Z_W-1:0]         z_next;
    logic [Z_W-1:0]         z_s3_reg;
    logic [Z_W-1:0]         z_s4_reg;
    logic [Z_W-1:0]         z_s5_reg;
    logic [Z_W-1:0]         z_s6_reg;
    logic                   keep_s4_reg;
    logic                   keep_s5_reg;
    logic                   keep_s6_reg;

    d2p_axis_cfg_t          cfg_x;
    d2p_axis_cfg_t          cfg_y;

    // The pipeline never stalls: items and configuration writes are always taken.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_focal_x_reg <= RST_INV_FOCAL;
            inv_focal_y_reg <= RST_INV_FOCAL;
            center_x_reg    <= RST_CENTER_X;
            center_y_reg    <= RST_CENTER_Y;
            mm_mode_reg     <= 1'b1;
            max_dist_reg    <= RST_MAX_DIST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_INV_FOCAL_X:     inv_focal_x_reg <= cfg_data[INV_W-1:0];
                REG_INV_FOCAL_Y:     inv_focal_y_reg <= cfg_data[INV_W-1:0];
                REG_CENTER_X:        center_x_reg    <= cfg_data[CTR_W-1:0];
                REG_CENTER_Y:        center_y_reg    <= cfg_data[CTR_W-1:0];
                REG_MILLIMETER_MODE: mm_mode_reg     <= cfg_data[0];
                REG_MAX_DISTANCE:    max_dist_reg    <= cfg_data[Z_W-1:0];
                default:             ;
            endcase
        end
    end

    // Valid bits travel alongside the data stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], accept};
        end
    end

    // Stage 2 input: raw*8192 + 62 times the reciprocal of 125.
    assign m_s1    = (M_W'(raw_s1_reg) << MM_SHIFT) + M_W'(MM_BIAS);
    assign qp_next = QP_W'(m_s1) * QP_W'(MM_RECIP);

    // Stage 3 input: the estimate is low by at most one; correct it, or take raw depth as is.
    always_comb
    begin
        qk = (QK_W'(q_s2_reg) + QK_W'(1)) * QK_W'(MM_DIV);
        if (!mm_mode_reg)
        begin
            z_next = Z_W'(raw_s2_reg) << FRAC_W;
        end
        else if (QK_W'(m_s2_reg) >= qk)
        begin
            z_next = Z_W'(q_s2_reg) + Z_W'(1);
        end
        else
        begin
            z_next = Z_W'(q_s2_reg);
        end
    end

    // Depth path and pass-through registers.
    always_ff @(posedge clk)
    begin
        raw_s1_reg  <= raw_depth;
        col_s1_reg  <= column;
        row_s1_reg  <= row;
        fe_reg      <= {fe_reg[PIPE_DEPTH-2:0], frame_end};
        q_s2_reg    <= qp_next[QP_W-1:RECIP_SH];
        m_s2_reg    <= m_s1;
        raw_s2_reg  <= raw_s1_reg;
        z_s3_reg    <= z_next;
        z_s4_reg    <= z_s3_reg;
        keep_s4_reg <= (z_s3_reg <= max_dist_reg);
        z_s5_reg    <= z_s4_reg;
        keep_s5_reg <= keep_s4_reg;
        z_s6_reg    <= z_s5_reg;
        keep_s6_reg <= keep_s5_reg;
    end

    // Axis units; z enters them at the partial-product stage.
    assign cfg_x = '{inv: inv_focal_x_reg, center: center_x_reg};
    assign cfg_y = '{inv: inv_focal_y_reg, center: center_y_reg};

    d2p_axis u_axis_x
    (
        .clk   (clk),
        .pix   (col_s1_reg),
        .cfg   (cfg_x),
        .z     (z_s3_reg),
        .coord (point_x)
    );

    d2p_axis u_axis_y
    (
        .clk   (clk),
        .pix   (row_s1_reg),
        .cfg   (cfg_y),
        .z     (z_s3_reg),
        .coord (point_y)
    );

    // Result ports.
    assign result_valid = vld_reg[PIPE_DEPTH-1];
    assign point_z      = z_s6_reg;
    assign keep         = keep_s6_reg;
    assign last_point   = fe_reg[PIPE_DEPTH-1];

    // Every accepted item is strobed out after the fixed latency, and only then.
    `D2P_ASSERT_DELAY(a_latency, accept, 6, result_valid)
    `D2P_ASSERT_IMPLY(a_no_spurious, result_valid, $past(accept, 6))
    // A point at zero depth projects onto the origin.
    `D2P_ASSERT_IMPLY(a_zero_depth, result_valid && (point_z == '0), (point_x == '0) && (point_y == '0))

endmodule

### tb/depth_to_point_backprojection_checker.sv
// Scoreboard for the depth-to-point back-projection block: watches the pixel, register and
// point channels, predicts every point and compares it with what the block emits.
// Depends on d2p_pkg for widths and register indexes.
module depth_to_point_backprojection_checker
    import d2p_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic [DEPTH_BITS-1:0]   raw_depth,
    input  logic [COORD_BITS-1:0]   column,
    input  logic [COORD_BITS-1:0]   row,
    input  logic                    frame_end,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    result_valid,
    input  logic signed [PT_W-1:0]  point_x,
    input  logic signed [PT_W-1:0]  point_y,
    input  logic [Z_W-1:0]          point_z,
    input  logic                    keep,
    input  logic                    last_point,
    output int                      fail_count,
    output int                      pending,
    output int                      points_checked,
    output int                      points_dropped
);
    timeunit 1ns;
    timeprecision 1ps;

    // Millimeters to meters, and the Q.4 offset times Q0.24 reciprocal scale.
    localparam longint unsigned MM_DIVISOR  = 1000;
    localparam int              ROUND_SHIFT = 4 + INV_W;
    localparam int              REPORT_CAP  = 200;

    typedef struct packed {
        logic [PT_W-1:0] x;
        logic [PT_W-1:0] y;
        logic [Z_W-1:0]  z;
        logic            keep;
        logic            last;
    } point_t;

    // Shadow copy of the intrinsics and limits.
    logic [INV_W-1:0] inv_fx;
    logic [INV_W-1:0] inv_fy;
    logic [CTR_W-1:0] ctr_x;
    logic [CTR_W-1:0] ctr_y;
    logic             mm_mode;
    logic [Z_W-1:0]   max_dist;

    // Points predicted for accepted pixels, oldest first.
    point_t points_due[$];

    // Depth in Q16.16, rounded to nearest in millimeter mode.
    function automatic logic [Z_W-1:0] scale_depth(input logic [DEPTH_BITS-1:0] raw,
                                                   input logic mm);
        logic [63:0] wide;
        wide = 64'(raw) << FRAC_W;
        if (mm)
            wide = (wide + MM_DIVISOR / 2) / MM_DIVISOR;
        return wide[Z_W-1:0];
    endfunction

    // (pixel.4 - center) * inv * z rounded half away from zero to Q.16, then saturated.
    function automatic logic [PT_W-1:0] backproject_axis(input logic [COORD_BITS-1:0] pix,
                                                         input logic [CTR_W-1:0] ctr,
                                                         input logic [INV_W-1:0] inv,
                                                         input logic [Z_W-1:0] z);
        longint     offset;
        logic       neg;
        logic [127:0] mag;
        logic [127:0] prod;
        logic [127:0] rounded;
        logic [127:0] pos_lim;
        logic [127:0] neg_lim;
        offset  = longint'({pix, 4'd0}) - longint'(ctr);
        neg     = offset < 0;
        mag     = neg ? 128'(-offset) : 128'(offset);
        prod    = mag * 128'(inv) * 128'(z);
        rounded = (prod + (128'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
        pos_lim = (128'd1 << (PT_W - 1)) - 128'd1;
        neg_lim = 128'd1 << (PT_W - 1);
        if (neg)
        begin
            if (rounded > neg_lim)
                rounded = neg_lim;
            rounded = -rounded;
        end
        else if (rounded > pos_lim)
        begin
            rounded = pos_lim;
        end
        return rounded[PT_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fail_count < REPORT_CAP)
            $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    // Check the emitted point, then record new pixels and register writes.
    always @(posedge clk or negedge rst_n)
    begin : watch
        point_t want;
        logic [Z_W-1:0] z;
        if (!rst_n)
        begin
            inv_fx   = RST_INV_FOCAL;
            inv_fy   = RST_INV_FOCAL;
            ctr_x    = RST_CENTER_X;
            ctr_y    = RST_CENTER_Y;
            mm_mode  = 1'b1;
            max_dist = RST_MAX_DIST;
            points_due.delete();
        end
        else
        begin
            if (result_valid)
            begin
                if (points_due.size() == 0)
                begin
                    report_mismatch("point emitted with no pixel pending", 64'(point_z),
                                    64'd0);
                end
                else
                begin
                    want = points_due.pop_front();
                    points_checked++;
                    if (!keep)
                        points_dropped++;
                    if (point_x !== want.x)
                        report_mismatch("point_x", 64'($unsigned(point_x)), 64'(want.x));
                    if (point_y !== want.y)
                        report_mismatch("point_y", 64'($unsigned(point_y)), 64'(want.y));
                    if (point_z !== want.z)
                        report_mismatch("point_z", 64'(point_z), 64'(want.z));
                    if (keep !== want.keep)
                        report_mismatch("keep", 64'(keep), 64'(want.keep));
                    if (last_point !== want.last)
                        report_mismatch("last_point", 64'(last_point), 64'(want.last));
                end
            end

            if (start && !busy)
            begin
                z         = scale_depth(raw_depth, mm_mode);
                want.x    = backproject_axis(column, ctr_x, inv_fx, z);
                want.y    = backproject_axis(row, ctr_y, inv_fy, z);
                want.z    = z;
                want.keep = z <= max_dist;
                want.last = frame_end;
                points_due.push_back(want);
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_INV_FOCAL_X:     inv_fx   = cfg_data[INV_W-1:0];
                    REG_INV_FOCAL_Y:     inv_fy   = cfg_data[INV_W-1:0];
                    REG_CENTER_X:        ctr_x    = cfg_data[CTR_W-1:0];
                    REG_CENTER_Y:        ctr_y    = cfg_data[CTR_W-1:0];
                    REG_MILLIMETER_MODE: mm_mode  = cfg_data[0];
                    REG_MAX_DISTANCE:    max_dist = cfg_data[Z_W-1:0];
                    default: ;
                endcase
            end
        end
        pending = points_due.size();
    end

endmodule

### tb/depth_to_point_backprojection_top_tb.sv
// Top of the depth-to-point back-projection testbench: clock, reset, pixel and register
// stimulus, and the verdict. Depends on d2p_pkg, the block and the checker module.
module depth_to_point_backprojection_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import d2p_pkg::*;

    localparam int RUN_LIMIT    = 200000;
    localparam int DRAIN_SETTLE = PIPE_DEPTH + 4;
    localparam int SEGMENTS     = 8;
    localparam int SEGMENT_LEN  = 100;

    // Indexes the block does not decode; writes to them must change nothing.
    localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [DEPTH_BITS-1:0]  raw_depth = '0;
    logic [COORD_BITS-1:0]  column = '0;
    logic [COORD_BITS-1:0]  row = '0;
    logic                   frame_end = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [IDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   result_valid;
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic [Z_W-1:0]         point_z;
    logic                   keep;
    logic                   last_point;

    int fail_count;
    int pending;
    int points_checked;
    int points_dropped;
    int pixels_sent = 0;
    int reg_writes = 0;
    int cycles = 0;

    always #2 clk = ~clk;

    depth_to_point_backprojection_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .raw_depth    (raw_depth),
        .column       (column),
        .row          (row),
        .frame_end    (frame_end),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .keep         (keep),
        .last_point   (last_point)
    );

    depth_to_point_backprojection_checker scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .raw_depth      (raw_depth),
        .column         (column),
        .row            (row),
        .frame_end      (frame_end),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .point_x        (point_x),
        .point_y        (point_y),
        .point_z        (point_z),
        .keep           (keep),
        .last_point     (last_point),
        .fail_count     (fail_count),
        .pending        (pending),
        .points_checked (points_checked),
        .points_dropped (points_dropped)
    );

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d points outstanding", cycles, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Offer one pixel, wait for it to be taken, then maybe leave the port idle a while.
    task automatic send_pixel(input logic [DEPTH_BITS-1:0] raw,
                              input logic [COORD_BITS-1:0] col,
                              input logic [COORD_BITS-1:0] rw, input logic fe,
                              input int idle_pct);
        start     <= 1'b1;
        raw_depth <= raw;
        column    <= col;
        row       <= rw;
        frame_end <= fe;
        do
            @(posedge clk);
        while (busy);
        pixels_sent++;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct);
        end
    endtask

    // Stop offering pixels until every predicted point has come out.
    task automatic settle_pipeline();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    // One register write; the caller lowers cfg_valid after the last of a batch.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        reg_writes++;
    endtask

    // Load a full intrinsics set; unused upper data bits carry junk to check masking.
    task automatic load_setting(input logic [INV_W-1:0] inv_x, input logic [INV_W-1:0] inv_y,
                                input logic [CTR_W-1:0] cx, input logic [CTR_W-1:0] cy,
                                input logic mm, input logic [Z_W-1:0] max_d);
        logic [CFG_W-1:0] junk;
        junk = $urandom();
        write_reg(REG_INV_FOCAL_X, {junk[31:24], inv_x});
        write_reg(REG_INV_FOCAL_Y, {junk[23:16], inv_y});
        write_reg(REG_CENTER_X, {junk[31:16], cx});
        write_reg(REG_CENTER_Y, {junk[15:0], cy});
        write_reg(REG_MILLIMETER_MODE, {junk[31:1], mm});
        write_reg(REG_MAX_DISTANCE, max_d);
        write_reg(REG_SPARE_A, $urandom());
        write_reg(REG_SPARE_B, $urandom());
        cfg_valid <= 1'b0;
    endtask

    // Pick a setting: mostly camera-like values, now and then an extreme.
    task automatic load_random_setting();
        logic [INV_W-1:0] inv_x;
        logic [INV_W-1:0] inv_y;
        logic [CTR_W-1:0] cx;
        logic [CTR_W-1:0] cy;
        logic             mm;
        logic [Z_W-1:0]   max_d;
        inv_x = ($urandom_range(0, 5) == 0) ? INV_W'($urandom())
                                             : INV_W'($urandom_range(8000, 200000));
        inv_y = ($urandom_range(0, 5) == 0) ? INV_W'($urandom())
                                             : INV_W'($urandom_range(8000, 200000));
        if ($urandom_range(0, 9) == 0)
            inv_x = '1;
        if ($urandom_range(0, 9) == 0)
            inv_y = '0;
        cx = ($urandom_range(0, 7) == 0) ? CTR_W'(0) : CTR_W'($urandom());
        cy = ($urandom_range(0, 7) == 0) ? '1 : CTR_W'($urandom());
        mm = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0:       max_d = '0;
            1:       max_d = '1;
            default: max_d = mm ? Z_W'($urandom_range(0, 5000000)) : Z_W'($urandom());
        endcase
        load_setting(inv_x, inv_y, cx, cy, mm, max_d);
    endtask

    initial
    begin : stimulus
        int idle_pct;
        int pick;
        logic [DEPTH_BITS-1:0] raw;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset intrinsics: depth and coordinate extremes, pixel on the principal point.
        send_pixel(16'd0, 12'd0, 12'd0, 1'b0, 24);
        send_pixel(16'hFFFF, 12'hFFF, 12'hFFF, 1'b1, 24);
        send_pixel(16'hFFFF, 12'd0, 12'd0, 1'b0, 24);
        send_pixel(16'd1000, 12'd320, 12'd200, 1'b0, 24);
        send_pixel(16'd1, 12'hFFF, 12'd0, 1'b0, 24);
        send_pixel(16'd500, 12'd0, 12'hFFF, 1'b1, 24);

        // Raw depth, largest reciprocals and offsets of both signs; limit equals deepest z.
        settle_pipeline();
        load_setting('1, '1, '1, '0, 1'b0, 32'hFFFF_0000);
        send_pixel(16'hFFFF, 12'd0, 12'hFFF, 1'b0, 24);
        send_pixel(16'hFFFF, 12'hFFF, 12'd0, 1'b1, 24);
        send_pixel(16'hFFFE, 12'd0, 12'd0, 1'b0, 24);
        send_pixel(16'd1, 12'hFFF, 12'hFFF, 1'b0, 24);

        // Millimeter mode with a 2 m limit: exactly at, just over and just under it.
        settle_pipeline();
        load_setting('0, '0, '0, '1, 1'b1, 32'd131072);
        send_pixel(16'd2000, 12'd17, 12'd99, 1'b0, 24);
        send_pixel(16'd2001, 12'd17, 12'd99, 1'b0, 24);
        send_pixel(16'd1999, 12'hFFF, 12'd0, 1'b1, 24);
        send_pixel(16'd0, 12'd0, 12'hFFF, 1'b0, 24);

        // Offsets of one sixteenth either way make exact half-unit ties; zero limit.
        settle_pipeline();
        load_setting(24'd2048, 24'd2048, 16'd15, 16'd17, 1'b0, 32'd0);
        send_pixel(16'd1, 12'd1, 12'd1, 1'b0, 0);
        send_pixel(16'd0, 12'd1, 12'd1, 1'b1, 0);
        send_pixel(16'd3, 12'd1, 12'd1, 1'b0, 0);

        // Random segments, each with its own setting and idle pattern.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            idle_pct = (seg < 3) ? 24 : (seg < 6) ? 64 : 0;
            settle_pipeline();
            load_random_setting();
            for (int n = 0; n < SEGMENT_LEN; n++)
            begin
                pick = $urandom_range(0, 9);
                case (pick)
                    0:       raw = '0;
                    1:       raw = '1;
                    2, 3:    raw = DEPTH_BITS'($urandom_range(0, 4000));
                    default: raw = DEPTH_BITS'($urandom());
                endcase
                send_pixel(raw, COORD_BITS'($urandom()), COORD_BITS'($urandom()),
                           $urandom_range(0, 15) == 0, idle_pct);
            end
        end

        // Drain and let the pipeline run empty before the verdict.
        settle_pipeline();
        repeat (DRAIN_SETTLE) @(negedge clk);

        $display("Sent %0d depth pixels under %0d register writes over %0d settings,",
                 pixels_sent, reg_writes, SEGMENTS + 3);
        $display("and checked %0d points, %0d of them beyond the distance limit.",
                 points_checked, points_dropped);
        if (fail_count == 0 && pending == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("%0d mismatches, %0d points never emitted", fail_count, pending);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
